@@ src/nsc_pkg.sv @@
// nsc_pkg: shared types, constants and codes of the NMEA sentence checker.
// Used by every module in src except nsc_checker; depends on nothing.
package nsc_pkg;

    localparam int HEADER_W     = 40;
    localparam int COMMAS_W     = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [HEADER_W-1:0] HEADER_RESET = 40'h47_50_59_42_4D; // "GPYBM"
    localparam logic [COMMAS_W-1:0] COMMAS_RESET = 6'd23;
    localparam logic [COMMAS_W-1:0] COMMAS_MAX   = 6'd63;

    localparam logic [COMMAS_W-1:0] MAIN_COMMA = 6'd16;
    localparam logic [COMMAS_W-1:0] VICE_COMMA = 6'd17;
    localparam logic [COMMAS_W-1:0] SAT_COMMA  = 6'd18;

    localparam logic [2:0] HEADER_LEN = 3'd5;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_COMMAS = 2'd1;

    // characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_FIVE   = 8'h35;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    typedef enum logic [2:0] {
        OUT_OK           = 3'd0,
        OUT_BAD_HEX      = 3'd1,
        OUT_SUM_MISMATCH = 3'd2,
        OUT_HEADER       = 3'd3,
        OUT_COMMAS       = 3'd4,
        OUT_MAIN_STATUS  = 3'd5,
        OUT_VICE_STATUS  = 3'd6
    } outcome_t;

    typedef enum logic [1:0] {
        TAIL_BODY    = 2'd0,
        TAIL_HEX_HI  = 2'd1,
        TAIL_HEX_LO  = 2'd2,
        TAIL_WAIT_LF = 2'd3
    } tail_t;

    // one classified word as it travels from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_dollar;
        logic       is_lf;
        logic       is_star;
        logic       is_comma;
        logic       is_digit;
        logic       is_status;  // '0'..'5'
        logic       hex_ok;     // '0'..'9' or 'A'..'F'
        logic [3:0] nibble;     // hex value, also the decimal digit value
    } byte_class_t;

    // queue status toward the back end
    typedef struct packed {
        logic valid;
    } queue_ctl_t;

endpackage

@@ src/nsc_front.sv @@
// nsc_front: input handshake and character classification.
// Depends on nsc_pkg.
module nsc_front (
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,
    input  logic                 q_full,
    output logic                 q_push,
    output nsc_pkg::byte_class_t q_item
);

    logic is_dec;
    logic is_uhex;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    assign is_dec  = (rx_byte >= nsc_pkg::CH_ZERO) && (rx_byte <= nsc_pkg::CH_NINE);
    assign is_uhex = (rx_byte >= nsc_pkg::CH_UPPER_A) && (rx_byte <= nsc_pkg::CH_UPPER_F);

    always_comb
    begin
        q_item           = '0;
        q_item.data      = rx_byte;
        q_item.is_dollar = (rx_byte == nsc_pkg::CH_DOLLAR);
        q_item.is_lf     = (rx_byte == nsc_pkg::CH_LF);
        q_item.is_star   = (rx_byte == nsc_pkg::CH_STAR);
        q_item.is_comma  = (rx_byte == nsc_pkg::CH_COMMA);
        q_item.is_digit  = is_dec;
        q_item.is_status = (rx_byte >= nsc_pkg::CH_ZERO) && (rx_byte <= nsc_pkg::CH_FIVE);
        q_item.hex_ok    = is_dec || is_uhex;
        if (is_uhex)
        begin
            // 'A'..'F' -> 10..15: low three bits are 1..6
            q_item.nibble = rx_byte[3:0] + 4'd9;
        end
        else if (is_dec)
        begin
            q_item.nibble = rx_byte[3:0];
        end
        else
        begin
            q_item.nibble = 4'd0;
        end
    end

endmodule

@@ src/nsc_queue.sv @@
// nsc_queue: small FIFO of classified words between front and back.
// Depends on nsc_pkg.
module nsc_queue #(
    parameter int DEPTH = nsc_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  nsc_pkg::byte_class_t push_item,
    output logic                 full,
    output nsc_pkg::queue_ctl_t  ctl_out,  // .valid driven here
    input  logic                 pop,
    output nsc_pkg::byte_class_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nsc_pkg::byte_class_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full          = (count_reg == CNT_W'(DEPTH));
    assign ctl_out.valid = (count_reg != '0);
    assign do_pop        = pop && (count_reg != '0);
    assign head_item     = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ src/nsc_back.sv @@
// nsc_back: sentence state, field capture, verdict and output register.
// Depends on nsc_pkg; fed by nsc_queue.
module nsc_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [nsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nsc_pkg::HEADER_W-1:0]   cfg_wdata,
    input  nsc_pkg::queue_ctl_t            q_ctl,   // .valid used here
    input  nsc_pkg::byte_class_t           q_item,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     outcome,
    output logic [2:0]                     main_status,
    output logic [2:0]                     vice_status,
    output logic [7:0]                     satellites,
    output logic [7:0]                     computed_sum
);

    localparam int HW = nsc_pkg::HEADER_W;
    localparam int CW = nsc_pkg::COMMAS_W;

    // configuration
    logic [HW-1:0] exp_header_reg;
    logic [CW-1:0] exp_commas_reg;

    // sentence state
    logic          in_sentence_reg, in_sentence_next;
    logic [7:0]    xor_acc_reg, xor_acc_next;
    logic [HW-1:0] header_shift_reg, header_shift_next;
    logic [2:0]    header_count_reg, header_count_next;
    logic [CW-1:0] comma_count_reg, comma_count_next;
    nsc_pkg::tail_t tail_reg, tail_next;
    logic [7:0]    recv_sum_reg, recv_sum_next;
    logic          hex_bad_reg, hex_bad_next;
    logic          main_ok_reg, main_ok_next;
    logic [2:0]    main_val_reg, main_val_next;
    logic          vice_ok_reg, vice_ok_next;
    logic [2:0]    vice_val_reg, vice_val_next;
    logic [7:0]    sat_acc_reg, sat_acc_next;
    logic          sat_frac_reg, sat_frac_next;
    logic          after_comma_reg, after_comma_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    nsc_pkg::outcome_t outcome_reg, verdict;
    logic [2:0]    main_out_reg, vice_out_reg;
    logic [7:0]    sat_out_reg, sum_out_reg;

    logic          step;        // a word is consumed this cycle
    logic          live;        // consumed word belongs to an open sentence
    logic          emit;
    logic          body;
    logic [11:0]   sat_mac;

    assign q_pop = q_ctl.valid && (!out_valid_reg || !out_stall);
    assign step  = q_pop;
    assign live  = step && in_sentence_reg && !q_item.is_dollar;
    assign emit  = live && q_item.is_lf;
    assign body  = live && !q_item.is_lf && (tail_reg == nsc_pkg::TAIL_BODY)
                   && !q_item.is_star;

    assign sat_mac = ({4'd0, sat_acc_reg} * 12'd10) + {8'd0, q_item.nibble};

    // tail phase sequencing
    always_comb
    begin
        tail_next = tail_reg;
        if (step && q_item.is_dollar)
        begin
            tail_next = nsc_pkg::TAIL_BODY;
        end
        else if (live && !q_item.is_lf)
        begin
            case (tail_reg)
                nsc_pkg::TAIL_BODY:    tail_next = q_item.is_star ? nsc_pkg::TAIL_HEX_HI
                                                                  : nsc_pkg::TAIL_BODY;
                nsc_pkg::TAIL_HEX_HI:  tail_next = nsc_pkg::TAIL_HEX_LO;
                nsc_pkg::TAIL_HEX_LO:  tail_next = nsc_pkg::TAIL_WAIT_LF;
                nsc_pkg::TAIL_WAIT_LF: tail_next = nsc_pkg::TAIL_WAIT_LF;
                default:               tail_next = nsc_pkg::TAIL_BODY;
            endcase
        end
    end

    // field datapath
    always_comb
    begin
        in_sentence_next  = in_sentence_reg;
        xor_acc_next      = xor_acc_reg;
        header_shift_next = header_shift_reg;
        header_count_next = header_count_reg;
        comma_count_next  = comma_count_reg;
        recv_sum_next     = recv_sum_reg;
        hex_bad_next      = hex_bad_reg;
        main_ok_next      = main_ok_reg;
        main_val_next     = main_val_reg;
        vice_ok_next      = vice_ok_reg;
        vice_val_next     = vice_val_reg;
        sat_acc_next      = sat_acc_reg;
        sat_frac_next     = sat_frac_reg;
        after_comma_next  = after_comma_reg;

        if (step && q_item.is_dollar)
        begin
            in_sentence_next  = 1'b1;
            xor_acc_next      = '0;
            header_shift_next = '0;
            header_count_next = '0;
            comma_count_next  = '0;
            recv_sum_next     = '0;
            hex_bad_next      = 1'b0;
            main_ok_next      = 1'b0;
            main_val_next     = '0;
            vice_ok_next      = 1'b0;
            vice_val_next     = '0;
            sat_acc_next      = '0;
            sat_frac_next     = 1'b0;
            after_comma_next  = 1'b0;
        end
        else if (emit)
        begin
            in_sentence_next = 1'b0;
        end
        else if (body)
        begin
            xor_acc_next = xor_acc_reg ^ q_item.data;
            if (header_count_reg < nsc_pkg::HEADER_LEN)
            begin
                header_shift_next = {header_shift_reg[HW-9:0], q_item.data};
                header_count_next = header_count_reg + 1'b1;
            end
            else
            begin
                if (after_comma_reg && (comma_count_reg == nsc_pkg::MAIN_COMMA))
                begin
                    main_ok_next  = q_item.is_status;
                    main_val_next = q_item.is_status ? q_item.nibble[2:0] : 3'd0;
                end
                if (after_comma_reg && (comma_count_reg == nsc_pkg::VICE_COMMA))
                begin
                    vice_ok_next  = q_item.is_status;
                    vice_val_next = q_item.is_status ? q_item.nibble[2:0] : 3'd0;
                end
                if (q_item.is_comma)
                begin
                    if (comma_count_reg != nsc_pkg::COMMAS_MAX)
                    begin
                        comma_count_next = comma_count_reg + 1'b1;
                    end
                    after_comma_next = 1'b1;
                end
                else
                begin
                    after_comma_next = 1'b0;
                    if ((comma_count_reg == nsc_pkg::SAT_COMMA) && !sat_frac_reg)
                    begin
                        if (q_item.is_digit)
                        begin
                            sat_acc_next = (sat_mac > 12'd255) ? 8'hFF : sat_mac[7:0];
                        end
                        else
                        begin
                            sat_frac_next = 1'b1;
                        end
                    end
                end
            end
        end
        else if (live && !q_item.is_lf)
        begin
            if (tail_reg == nsc_pkg::TAIL_HEX_HI || tail_reg == nsc_pkg::TAIL_HEX_LO)
            begin
                if (!q_item.hex_ok)
                begin
                    hex_bad_next = 1'b1;
                end
                if (tail_reg == nsc_pkg::TAIL_HEX_HI)
                begin
                    recv_sum_next = {q_item.nibble, 4'd0};
                end
                else
                begin
                    recv_sum_next = {recv_sum_reg[7:4], q_item.nibble};
                end
            end
        end
    end

    // verdict: first failing check wins
    always_comb
    begin
        if ((tail_reg != nsc_pkg::TAIL_WAIT_LF) || hex_bad_reg)
        begin
            verdict = nsc_pkg::OUT_BAD_HEX;
        end
        else if (recv_sum_reg != xor_acc_reg)
        begin
            verdict = nsc_pkg::OUT_SUM_MISMATCH;
        end
        else if ((header_count_reg != nsc_pkg::HEADER_LEN)
                 || (header_shift_reg != exp_header_reg))
        begin
            verdict = nsc_pkg::OUT_HEADER;
        end
        else if (comma_count_reg != exp_commas_reg)
        begin
            verdict = nsc_pkg::OUT_COMMAS;
        end
        else if (!main_ok_reg)
        begin
            verdict = nsc_pkg::OUT_MAIN_STATUS;
        end
        else if (!vice_ok_reg)
        begin
            verdict = nsc_pkg::OUT_VICE_STATUS;
        end
        else
        begin
            verdict = nsc_pkg::OUT_OK;
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_header_reg   <= nsc_pkg::HEADER_RESET;
            exp_commas_reg   <= nsc_pkg::COMMAS_RESET;
            in_sentence_reg  <= 1'b0;
            xor_acc_reg      <= '0;
            header_shift_reg <= '0;
            header_count_reg <= '0;
            comma_count_reg  <= '0;
            tail_reg         <= nsc_pkg::TAIL_BODY;
            recv_sum_reg     <= '0;
            hex_bad_reg      <= 1'b0;
            main_ok_reg      <= 1'b0;
            main_val_reg     <= '0;
            vice_ok_reg      <= 1'b0;
            vice_val_reg     <= '0;
            sat_acc_reg      <= '0;
            sat_frac_reg     <= 1'b0;
            after_comma_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == nsc_pkg::REG_EXPECTED_HEADER))
            begin
                exp_header_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == nsc_pkg::REG_EXPECTED_COMMAS))
            begin
                exp_commas_reg <= cfg_wdata[CW-1:0];
            end
            in_sentence_reg  <= in_sentence_next;
            xor_acc_reg      <= xor_acc_next;
            header_shift_reg <= header_shift_next;
            header_count_reg <= header_count_next;
            comma_count_reg  <= comma_count_next;
            tail_reg         <= tail_next;
            recv_sum_reg     <= recv_sum_next;
            hex_bad_reg      <= hex_bad_next;
            main_ok_reg      <= main_ok_next;
            main_val_reg     <= main_val_next;
            vice_ok_reg      <= vice_ok_next;
            vice_val_reg     <= vice_val_next;
            sat_acc_reg      <= sat_acc_next;
            sat_frac_reg     <= sat_frac_next;
            after_comma_reg  <= after_comma_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // result payload, loaded only with a verdict
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            outcome_reg  <= verdict;
            main_out_reg <= main_val_reg;
            vice_out_reg <= vice_val_reg;
            sat_out_reg  <= sat_acc_reg;
            sum_out_reg  <= xor_acc_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign outcome      = outcome_reg;
    assign main_status  = main_out_reg;
    assign vice_status  = vice_out_reg;
    assign satellites   = sat_out_reg;
    assign computed_sum = sum_out_reg;

endmodule

@@ src/nmea_sentence_checker_top.sv @@
// nmea_sentence_checker_top: NMEA sentence checksum and field checker.
// Instantiates nsc_front, nsc_queue and nsc_back; depends on nsc_pkg.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  input    | in_valid / in_stall   | rx_byte
//  result   | out_valid / out_stall | outcome, main_status, vice_status,
//           |                       | satellites, computed_sum
//  config   | cfg_we                | cfg_index, cfg_wdata (no read-back)
//
// One word per cycle sustained while no verdict is held by out_stall. A taken
// line feed is written into the queue; from the queue head the sentence engine
// runs it into the output register, where the verdict shows. Words waiting
// ahead of it in the queue delay the verdict.
// Reset clears the queue and all sentence state at once and loads the
// config registers with "GPYBM" and 23 commas; no clearing pass.
// in_stall rises only when the queue is full, which happens only while a
// finished verdict is held by out_stall; the queue depth sets how many words
// still get in after the result side stalls.
module nmea_sentence_checker_top #(
    parameter int QUEUE_DEPTH = nsc_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // config write port
    input  logic                          cfg_we,
    input  logic [nsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nsc_pkg::HEADER_W-1:0]  cfg_wdata,
    // byte stream in
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    rx_byte,
    // verdicts out
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    outcome,
    output logic [2:0]                    main_status,
    output logic [2:0]                    vice_status,
    output logic [7:0]                    satellites,
    output logic [7:0]                    computed_sum
);

    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    nsc_pkg::byte_class_t push_item;
    nsc_pkg::byte_class_t head_item;
    nsc_pkg::queue_ctl_t  q_ctl;

    // front: handshake and per-character classification
    nsc_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    // decoupling queue; lets the input keep flowing while a verdict waits
    nsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .ctl_out   (q_ctl),
        .pop       (q_pop),
        .head_item (head_item)
    );

    // back: sentence engine and result register
    nsc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .q_ctl        (q_ctl),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .outcome      (outcome),
        .main_status  (main_status),
        .vice_status  (vice_status),
        .satellites   (satellites),
        .computed_sum (computed_sum)
    );

endmodule

@@ src/nsc_checker.sv @@
// nsc_checker: port-level assertions for nmea_sentence_checker_top.
// Depends on nothing; bound to the top level at the end of this file.
module nsc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [2:0]                    outcome,
    input logic [2:0]                    main_status,
    input logic [2:0]                    vice_status,
    input logic [7:0]                    satellites,
    input logic [7:0]                    computed_sum
);

    // a held verdict stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(outcome)
            && $stable(main_status) && $stable(vice_status)
            && $stable(satellites) && $stable(computed_sum))
        else $error("held verdict changed");

    // only the seven defined outcome codes are ever shown
    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> outcome != 3'd7)
        else $error("undefined outcome code");

    // input backpressure only follows a stalled verdict
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
        else $error("input stalled without a stalled verdict");

endmodule

bind nmea_sentence_checker_top nsc_checker u_nsc_checker (.*);
